// File: rtl/lcg_pkg.sv
// Shared widths, types and item formats for the line color gradient pipeline.
`timescale 1ns / 1ps

package lcg_pkg;

  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int DmagBits  = CoordBits;
  // The numerator magnitude stays below 510 * (2**CoordBits - 1).
  localparam int NmagBits  = CoordBits + 9;
  localparam int NumBits   = NmagBits + 1;
  localparam int ChBits    = 8;
  localparam int NumCh     = 3;
  localparam int ColorBits = ChBits * NumCh;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic [ColorBits-1:0]        color_t;
  typedef logic [ChBits-1:0]           chan_t;

  // Progress and span along the major axis.
  typedef struct packed {
    diff_t  num;
    diff_t  den;
    color_t ca;
    color_t cb;
  } axis_t;

  // Operands of the unsigned dividers, one numerator per channel.
  typedef struct packed {
    logic [NumCh-1:0][NmagBits-1:0] nmag;
    logic [NumCh-1:0]               neg;
    logic [DmagBits-1:0]            dmag;
    logic                           zero;
    color_t                         ca;
  } quot_in_t;

  typedef struct packed {
    logic [NumCh-1:0][ChBits-1:0] q;
    logic [NumCh-1:0]             neg;
    logic                         zero;
    color_t                       ca;
  } quot_out_t;

endpackage

// File: rtl/lcg_front.sv
// Front stages: coordinate differences, then major axis selection.
`timescale 1ns / 1ps

module lcg_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lcg_pkg::coord_t px,
  input  lcg_pkg::coord_t py,
  input  lcg_pkg::coord_t sx,
  input  lcg_pkg::coord_t sy,
  input  lcg_pkg::coord_t ex,
  input  lcg_pkg::coord_t ey,
  input  lcg_pkg::color_t ca,
  input  lcg_pkg::color_t cb,
  output logic            out_valid,
  input  logic            out_ready,
  output lcg_pkg::axis_t  out_axis
);
  import lcg_pkg::*;

  typedef struct packed {
    diff_t  dx;
    diff_t  dy;
    diff_t  nx;
    diff_t  ny;
    color_t ca;
    color_t cb;
  } span_t;

  span_t s1_r, s1_nxt;
  axis_t s2_r, s2_nxt;
  logic  v1_r, v2_r;
  logic  rdy1, rdy2;
  logic [DiffBits-1:0] adx, ady;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s1_nxt.dx = {ex[CoordBits-1], ex} - {sx[CoordBits-1], sx};
    s1_nxt.dy = {ey[CoordBits-1], ey} - {sy[CoordBits-1], sy};
    s1_nxt.nx = {px[CoordBits-1], px} - {sx[CoordBits-1], sx};
    s1_nxt.ny = {py[CoordBits-1], py} - {sy[CoordBits-1], sy};
    s1_nxt.ca = ca;
    s1_nxt.cb = cb;
  end

  always_comb begin
    adx = s1_r.dx[DiffBits-1] ? (~s1_r.dx + DiffBits'(1)) : s1_r.dx;
    ady = s1_r.dy[DiffBits-1] ? (~s1_r.dy + DiffBits'(1)) : s1_r.dy;
    if (adx >= ady) begin
      s2_nxt.num = s1_r.nx;
      s2_nxt.den = s1_r.dx;
    end else begin
      s2_nxt.num = s1_r.ny;
      s2_nxt.den = s1_r.dy;
    end
    s2_nxt.ca = s1_r.ca;
    s2_nxt.cb = s1_r.cb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)     s2_r <= s2_nxt;
  end

  assign out_valid = v2_r;
  assign out_axis  = s2_r;

endmodule

// File: rtl/lcg_prod.sv
// Numerator stages: per-channel products, their sum, then sign and magnitude split.
`timescale 1ns / 1ps

module lcg_prod (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcg_pkg::axis_t    in_axis,
  output logic              out_valid,
  input  logic              out_ready,
  output lcg_pkg::quot_in_t out_quot
);
  import lcg_pkg::*;

  typedef struct packed {
    logic [NumCh-1:0][NumBits-1:0] pa;
    logic [NumCh-1:0][NumBits-1:0] pb;
    diff_t                         den;
    color_t                        ca;
  } prod_t;

  typedef struct packed {
    logic [NumCh-1:0][NumBits-1:0] n;
    diff_t                         den;
    color_t                        ca;
  } sum_t;

  prod_t    s3_r, s3_nxt;
  sum_t     s4_r, s4_nxt;
  quot_in_t s5_r, s5_nxt;
  logic     v3_r, v4_r, v5_r;
  logic     rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign in_ready = rdy3;

  // start * den and progress * (end - start), each channel on its own multipliers.
  always_comb begin
    logic signed [ChBits:0] a_s;
    logic signed [ChBits:0] d_s;
    for (int ch = 0; ch < NumCh; ch++) begin
      a_s = {1'b0, in_axis.ca[ch*ChBits +: ChBits]};
      d_s = {1'b0, in_axis.cb[ch*ChBits +: ChBits]} - {1'b0, in_axis.ca[ch*ChBits +: ChBits]};
      s3_nxt.pa[ch] = NumBits'(a_s) * NumBits'(in_axis.den);
      s3_nxt.pb[ch] = NumBits'(d_s) * NumBits'(in_axis.num);
    end
    s3_nxt.den = in_axis.den;
    s3_nxt.ca  = in_axis.ca;
  end

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      s4_nxt.n[ch] = s3_r.pa[ch] + s3_r.pb[ch];
    end
    s4_nxt.den = s3_r.den;
    s4_nxt.ca  = s3_r.ca;
  end

  // Truncation toward zero: divide magnitudes, then apply the quotient sign.
  always_comb begin
    logic [NumBits-1:0]  mag;
    logic [DiffBits-1:0] dabs;
    for (int ch = 0; ch < NumCh; ch++) begin
      mag = s4_r.n[ch][NumBits-1] ? (~s4_r.n[ch] + NumBits'(1)) : s4_r.n[ch];
      s5_nxt.nmag[ch] = mag[NmagBits-1:0];
      s5_nxt.neg[ch]  = s4_r.n[ch][NumBits-1] ^ s4_r.den[DiffBits-1];
    end
    dabs = s4_r.den[DiffBits-1] ? (~s4_r.den + DiffBits'(1)) : s4_r.den;
    s5_nxt.dmag = dabs[DmagBits-1:0];
    s5_nxt.zero = (s4_r.den == '0);
    s5_nxt.ca   = s4_r.ca;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= in_valid;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) s3_r <= s3_nxt;
    if (rdy4 && v3_r)     s4_r <= s4_nxt;
    if (rdy5 && v4_r)     s5_r <= s5_nxt;
  end

  assign out_valid = v5_r;
  assign out_quot  = s5_r;

endmodule

// File: rtl/lcg_div.sv
// Pipelined restoring dividers, one quotient bit per stage for all three channels.
`timescale 1ns / 1ps

module lcg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lcg_pkg::quot_in_t  in_quot,
  output logic               out_valid,
  input  logic               out_ready,
  output lcg_pkg::quot_out_t out_quot
);
  import lcg_pkg::*;

  typedef struct packed {
    logic [NumCh-1:0]    neg;
    logic [DmagBits-1:0] dmag;
    logic                zero;
    color_t              ca;
  } side_t;

  // Index g holds what enters stage g; index NmagBits is the last stage's output.
  logic                           vs     [NmagBits+1];
  logic                           rdy    [NmagBits+1];
  logic [NumCh-1:0][ChBits-1:0]   q_s    [NmagBits+1];
  side_t                          side_s [NmagBits+1];
  logic [NumCh-1:0][DmagBits-1:0] rem_s  [NmagBits];
  logic [NumCh-1:0][NmagBits-1:0] dvd_s  [NmagBits];

  assign vs[0]            = in_valid;
  assign q_s[0]           = '0;
  assign rem_s[0]         = '0;
  assign dvd_s[0]         = in_quot.nmag;
  assign side_s[0].neg    = in_quot.neg;
  assign side_s[0].dmag   = in_quot.dmag;
  assign side_s[0].zero   = in_quot.zero;
  assign side_s[0].ca     = in_quot.ca;
  assign rdy[NmagBits]    = out_ready;
  assign in_ready         = rdy[0];

  for (genvar g = 0; g < NmagBits; g++) begin : g_stage
    logic                           v_r;
    logic [NumCh-1:0][ChBits-1:0]   q_r, q_nxt;
    logic [NumCh-1:0][DmagBits-1:0] rem_nxt;
    logic [NumCh-1:0][NmagBits-1:0] dvd_nxt;
    side_t                          side_r;

    assign rdy[g] = !v_r || rdy[g+1];

    always_comb begin
      logic [DmagBits:0]   cur;
      logic [DmagBits+1:0] trial;
      for (int ch = 0; ch < NumCh; ch++) begin
        cur   = {rem_s[g][ch], dvd_s[g][ch][NmagBits-1]};
        trial = {1'b0, cur} - {2'b00, side_s[g].dmag};
        if (!trial[DmagBits+1]) begin
          rem_nxt[ch] = trial[DmagBits-1:0];
          q_nxt[ch]   = {q_s[g][ch][ChBits-2:0], 1'b1};
        end else begin
          rem_nxt[ch] = cur[DmagBits-1:0];
          q_nxt[ch]   = {q_s[g][ch][ChBits-2:0], 1'b0};
        end
        dvd_nxt[ch] = {dvd_s[g][ch][NmagBits-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (rdy[g]) begin
        v_r <= vs[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && vs[g]) begin
        q_r    <= q_nxt;
        side_r <= side_s[g];
      end
    end

    assign vs[g+1]     = v_r;
    assign q_s[g+1]    = q_r;
    assign side_s[g+1] = side_r;

    // The last stage needs no partial remainder or dividend afterwards.
    if (g < NmagBits - 1) begin : g_carry
      logic [NumCh-1:0][DmagBits-1:0] rem_r;
      logic [NumCh-1:0][NmagBits-1:0] dvd_r;

      always_ff @(posedge clk) begin
        if (rdy[g] && vs[g]) begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_nxt;
        end
      end

      assign rem_s[g+1] = rem_r;
      assign dvd_s[g+1] = dvd_r;
    end
  end

  assign out_valid     = vs[NmagBits];
  assign out_quot.q    = q_s[NmagBits];
  assign out_quot.neg  = side_s[NmagBits].neg;
  assign out_quot.zero = side_s[NmagBits].zero;
  assign out_quot.ca   = side_s[NmagBits].ca;

endmodule

// File: rtl/line_color_gradient.sv
// Top level of the line color gradient pipeline with its output register.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ---------------------------------------------
//  input     in_valid / in_ready    in_pixel_x/y, in_start_x/y, in_end_x/y,
//                                   in_start_color, in_end_color
//  result    out_valid / out_ready  out_pixel_color
//
// One item enters per cycle unless out_ready holds the pipeline; each accepted item
// passes two front stages, three numerator stages, 25 divider stages (one quotient bit
// each) and the output register on its way to out_valid.
// Synchronous active-low reset empties every stage; data registers are not reset.
// A stall holds only the stages that are full, so empty stages keep taking items.
`timescale 1ns / 1ps

module line_color_gradient (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lcg_pkg::coord_t in_pixel_x,
  input  lcg_pkg::coord_t in_pixel_y,
  input  lcg_pkg::coord_t in_start_x,
  input  lcg_pkg::coord_t in_start_y,
  input  lcg_pkg::coord_t in_end_x,
  input  lcg_pkg::coord_t in_end_y,
  input  lcg_pkg::color_t in_start_color,
  input  lcg_pkg::color_t in_end_color,
  output logic            out_valid,
  input  logic            out_ready,
  output lcg_pkg::color_t out_pixel_color
);
  import lcg_pkg::*;

  axis_t     axis;
  quot_in_t  prod_o;
  quot_out_t div_o;
  logic      front_valid, front_ready;
  logic      prod_valid, prod_ready;
  logic      div_valid, div_ready;
  logic      out_valid_r;
  color_t    out_pixel_color_r, out_pixel_color_nxt;

  lcg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .px        (in_pixel_x),
    .py        (in_pixel_y),
    .sx        (in_start_x),
    .sy        (in_start_y),
    .ex        (in_end_x),
    .ey        (in_end_y),
    .ca        (in_start_color),
    .cb        (in_end_color),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_axis  (axis)
  );

  lcg_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_axis   (axis),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_quot  (prod_o)
  );

  lcg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_quot   (prod_o),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quot  (div_o)
  );

  assign div_ready = !out_valid_r || out_ready;

  // A zero span gives the start color; otherwise the signed quotient wraps to 8 bits.
  always_comb begin
    chan_t qc;
    for (int ch = 0; ch < NumCh; ch++) begin
      qc = div_o.q[ch];
      if (div_o.zero) begin
        out_pixel_color_nxt[ch*ChBits +: ChBits] = div_o.ca[ch*ChBits +: ChBits];
      end else if (div_o.neg[ch]) begin
        out_pixel_color_nxt[ch*ChBits +: ChBits] = ~qc + ChBits'(1);
      end else begin
        out_pixel_color_nxt[ch*ChBits +: ChBits] = qc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready && div_valid) out_pixel_color_r <= out_pixel_color_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_pixel_color_r;

`ifndef SYNTH
  a_zero_span_color: assert property (@(posedge clk) disable iff (!rst_n)
    (div_valid && div_ready && div_o.zero) |=> (out_pixel_color == $past(div_o.ca)))
    else $error("zero-span item did not produce its start color");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    prod_valid |-> (prod_o.zero == (prod_o.dmag == '0)))
    else $error("zero-span flag disagrees with divisor magnitude");
`endif

endmodule

// File: dv/tb_line_color_gradient.sv
// Testbench for line_color_gradient: random and directed pixels checked against a local predictor.
`timescale 1ns / 1ps

module tb_line_color_gradient;
  import lcg_pkg::*;

  localparam int RandItems   = 1300;
  localparam int IdleLimit   = 2000;
  localparam int SettleTicks = 40;

  typedef struct {
    coord_t px, py, sx, sy, ex, ey;
    color_t c0, c1;
    bit     drain;
  } pix_item_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_pixel_x = '0;
  coord_t in_pixel_y = '0;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  color_t in_start_color = '0;
  color_t in_end_color = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  color_t out_pixel_color;

  pix_item_t pixel_q[$];
  color_t    color_q[$];
  int        errors = 0;
  bit        in_taken = 1'b0;
  int        idle_cycles = 0;
  int        gap_left = 0;
  int        burst_left = 8;
  int        tick = 0;
  longint    ext_vals [5] = '{-32768, 32767, 0, -1, 1};

  line_color_gradient dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_start_color (in_start_color),
    .in_end_color   (in_end_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_color(out_pixel_color)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Exact rational interpolation per channel, truncated toward zero, low byte kept.
  function automatic color_t interp_color(coord_t px, coord_t py, coord_t sx, coord_t sy,
                                          coord_t ex, coord_t ey, color_t c0, color_t c1);
    longint dx, dy, num, den, ca, cb, q;
    color_t res;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) begin
      num = longint'(px) - longint'(sx);
      den = dx;
    end else begin
      num = longint'(py) - longint'(sy);
      den = dy;
    end
    for (int ch = 0; ch < NumCh; ch++) begin
      ca = longint'(c0[ch*ChBits +: ChBits]);
      cb = longint'(c1[ch*ChBits +: ChBits]);
      q = (den == 0) ? ca : (ca * den + num * (cb - ca)) / den;
      res[ch*ChBits +: ChBits] = q[ChBits-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic add_pixel(input longint px, py, sx, sy, ex, ey, input color_t c0, c1,
                           input bit drain = 1'b0);
    pix_item_t it;
    it.px = coord_t'(px);
    it.py = coord_t'(py);
    it.sx = coord_t'(sx);
    it.sy = coord_t'(sy);
    it.ex = coord_t'(ex);
    it.ey = coord_t'(ey);
    it.c0 = c0;
    it.c1 = c1;
    it.drain = drain;
    pixel_q.push_back(it);
  endtask

  // Sender: bursts of items separated by random gaps; an item marked drain waits
  // until every earlier color has come out.
  always @(negedge clk) begin : drive_proc
    pix_item_t nx;
    logic      v_next;
    if (rst_n && !(in_valid && !in_taken)) begin
      v_next = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pixel_q.size() > 0 && !(pixel_q[0].drain && color_q.size() > 0)) begin
        nx = pixel_q.pop_front();
        in_pixel_x     <= nx.px;
        in_pixel_y     <= nx.py;
        in_start_x     <= nx.sx;
        in_start_y     <= nx.sy;
        in_end_x       <= nx.ex;
        in_end_y       <= nx.ey;
        in_start_color <= nx.c0;
        in_end_color   <= nx.c1;
        v_next = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
      in_valid <= v_next;
    end
  end

  // Receiver: cycles through free flow, random, periodic and heavy stall patterns.
  always @(negedge clk) begin
    tick++;
    case ((tick / 300) % 4)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        out_ready <= (tick % 7) >= 3;
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  always @(posedge clk) begin : monitor_proc
    color_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) begin
        if (color_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel color %06h", out_pixel_color));
        end else begin
          want = color_q.pop_front();
          if (out_pixel_color !== want)
            report_mismatch($sformatf("pixel color %06h, predicted %06h",
                                      out_pixel_color, want));
        end
      end
      if (in_valid && in_ready === 1'b1)
        color_q.push_back(interp_color(in_pixel_x, in_pixel_y, in_start_x, in_start_y,
                                       in_end_x, in_end_y, in_start_color, in_end_color));
      in_taken <= in_valid && in_ready === 1'b1;
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("timeout: no item moved for %0d cycles", IdleLimit);
          $display("line_color_gradient test failed");
          $finish;
        end
      end
    end
  end

  initial begin : stim_proc
    longint sx, sy, ex, ey, px, py, dx, dy, span, k, d;
    color_t c0, c1;
    int     mode;

    // Same endpoint twice: the span is zero and the start color comes back.
    add_pixel(100, -7, 5, 5, 5, 5, 24'h123456, 24'hABCDEF);
    add_pixel(32767, -32768, -32768, 32767, -32768, 32767, 24'hFFFFFF, 24'h000000);
    // X-major line at its start, end and middle.
    add_pixel(0, 0, 0, 0, 100, 10, 24'h000000, 24'hFFFFFF);
    add_pixel(100, 10, 0, 0, 100, 10, 24'h000000, 24'hFFFFFF);
    add_pixel(50, 5, 0, 0, 100, 10, 24'h000000, 24'hFFFFFF);
    // Negative spans on both axes.
    add_pixel(-30, 0, 0, 0, -60, 20, 24'hFF0080, 24'h00FF7F);
    add_pixel(3, 25, 0, 0, 10, 100, 24'h102030, 24'hF0E0D0);
    add_pixel(0, -77, 0, 0, 10, -100, 24'h102030, 24'hF0E0D0);
    // Equal spans pick the x axis.
    add_pixel(40, -3, 0, 0, 50, 50, 24'h00FF00, 24'hFF00FF);
    add_pixel(10, 40, 0, 0, 50, -50, 24'h00FF00, 24'hFF00FF);
    // Widest spans.
    add_pixel(32767, 0, -32768, 0, 32767, 0, 24'h000000, 24'hFFFFFF);
    add_pixel(0, 0, -32768, 0, 32767, 0, 24'h000000, 24'hFFFFFF);
    add_pixel(-32768, 0, -32768, 0, 32767, 0, 24'h000000, 24'hFFFFFF);
    add_pixel(0, -32768, 0, 32767, 0, -32768, 24'hFFFFFF, 24'h000000);
    add_pixel(0, 0, 0, 32767, 0, -32768, 24'hFFFFFF, 24'h000000);
    // Pixels off the segment extrapolate and can wrap a channel; the last lies on a flat-color segment.
    add_pixel(200, 0, 0, 0, 100, 0, 24'h000000, 24'h804020);
    add_pixel(-32768, 0, 0, 0, 1, 0, 24'h0A0B0C, 24'h0B0C0D);
    add_pixel(32767, 0, -32768, 0, -32767, 0, 24'hFF00FF, 24'h00FF00);
    add_pixel(7, 0, 0, 0, 9, 0, 24'h5A5A5A, 24'h5A5A5A);

    for (int n = 0; n < RandItems; n++) begin
      mode = $urandom_range(0, 9);
      c0 = color_t'($urandom());
      c1 = color_t'($urandom());
      if ($urandom_range(0, 4) == 0) c0 = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      if ($urandom_range(0, 4) == 0) c1 = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      if (mode <= 5) begin
        // A pixel on or near a proper line, mostly short lines.
        case ($urandom_range(0, 3))
          0: span = 32767;
          1: span = 2000;
          default: span = 40;
        endcase
        sx = longint'($urandom_range(0, 2 * span)) - span;
        sy = longint'($urandom_range(0, 2 * span)) - span;
        ex = longint'($urandom_range(0, 2 * span)) - span;
        ey = longint'($urandom_range(0, 2 * span)) - span;
        k = longint'($urandom_range(0, 256));
        px = sx + ((ex - sx) * k) / 256;
        py = sy + ((ey - sy) * k) / 256;
        if ($urandom_range(0, 3) == 0) begin
          px = px + longint'($urandom_range(0, 6)) - 3;
          py = py + longint'($urandom_range(0, 6)) - 3;
        end
      end else if (mode <= 7) begin
        sx = longint'($urandom_range(0, 65535));
        sy = longint'($urandom_range(0, 65535));
        ex = longint'($urandom_range(0, 65535));
        ey = longint'($urandom_range(0, 65535));
        px = longint'($urandom_range(0, 65535));
        py = longint'($urandom_range(0, 65535));
      end else if (mode == 8) begin
        // Equal or zero spans.
        d = ($urandom_range(0, 3) == 0) ? longint'(0) : longint'($urandom_range(1, 300));
        sx = longint'($urandom_range(0, 2000)) - 1000;
        sy = longint'($urandom_range(0, 2000)) - 1000;
        ex = sx + ($urandom_range(0, 1) ? d : -d);
        ey = sy + ($urandom_range(0, 1) ? d : -d);
        px = sx + longint'($urandom_range(0, 600)) - 300;
        py = sy + longint'($urandom_range(0, 600)) - 300;
      end else begin
        sx = ext_vals[$urandom_range(0, 4)];
        sy = ext_vals[$urandom_range(0, 4)];
        ex = ext_vals[$urandom_range(0, 4)];
        ey = ext_vals[$urandom_range(0, 4)];
        px = ext_vals[$urandom_range(0, 4)];
        py = ext_vals[$urandom_range(0, 4)];
      end
      add_pixel(px, py, sx, sy, ex, ey, c0, c1, n == 0 || n == RandItems / 2);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pixel_q.size() > 0 || in_valid || color_q.size() > 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
    if (color_q.size() != 0)
      report_mismatch($sformatf("%0d predicted colors never came out", color_q.size()));
    if (errors == 0) begin
      $display("line_color_gradient test passed");
    end else begin
      $display("line_color_gradient test failed");
    end
    $finish;
  end

endmodule
